// File: hdl/ray_triangle_intersection_top_assert.svh
// Assertion macros for the ray-triangle intersection block
`ifndef RAY_TRIANGLE_INTERSECTION_TOP_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECTION_TOP_ASSERT_SVH

// Same-cycle implication
`define RTI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RTI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles
`define RTI_ASSERT_LAT(label, clk, rst_n, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
    else $error(msg);

`endif

// File: hdl/rti_pkg.sv
// Shared widths, register indexes and types of the ray-triangle intersection block
package rti_pkg;

  localparam int CW     = 16;            // coordinate width
  localparam int FRAC   = 16;            // fraction bits of u, v and t
  localparam int EW     = CW + 1;        // edge and offset width
  localparam int PW     = CW + EW + 1;   // dir x e2 width
  localparam int QW     = 2 * EW + 1;    // s x e1 width
  localparam int SW     = EW + QW + 2;   // dot product width
  localparam int NW     = SW + FRAC;     // dividend and quotient magnitude width
  localparam int OW     = 48;            // distance width
  localparam int FLOORW = 32;
  localparam int MARGW  = 16;
  localparam int NLANE  = 3;             // u, v, t
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int LAT_OUT = NW + 8;       // accept edge to result strobe

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_ORG_X  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ORG_Y  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ORG_Z  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DIR_X  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DIR_Y  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_DIR_Z  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_FLOOR  = 3'd6;
  localparam logic [CFG_AW-1:0] REG_MARGIN = 3'd7;

  localparam logic [OW-1:0] DIST_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] DIST_MIN = {1'b1, {(OW-1){1'b0}}};
  localparam logic signed [NW+1:0] ONE_W = {{(NW+1-FRAC){1'b0}}, 1'b1, {FRAC{1'b0}}};

  // Lane order in the divider
  localparam int LANE_U = 0;
  localparam int LANE_V = 1;
  localparam int LANE_T = 2;

  typedef struct packed {
    logic             det_miss;
    logic [NLANE-1:0] q_neg;
  } rti_side_t;

endpackage

// File: hdl/rti_div.sv
// Pipelined restoring divider: three quotients over one shared divisor, one bit a stage
module rti_div (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  rti_pkg::rti_side_t                        side_i,
  input  logic [rti_pkg::SW-1:0]                    den_i,
  input  logic [rti_pkg::NLANE-1:0][rti_pkg::NW-1:0] num_i,
  output logic                                      valid_o,
  output rti_pkg::rti_side_t                        side_o,
  output logic [rti_pkg::NLANE-1:0][rti_pkg::NW-1:0] quo_o
);

  logic                                       vld_q  [rti_pkg::NW];
  rti_pkg::rti_side_t                         side_q [rti_pkg::NW];
  logic [rti_pkg::SW-1:0]                     den_q  [rti_pkg::NW];
  logic [rti_pkg::NLANE-1:0][rti_pkg::SW-1:0] rem_q  [rti_pkg::NW];
  logic [rti_pkg::NLANE-1:0][rti_pkg::NW-1:0] nq_q   [rti_pkg::NW];

  logic                                       vld_d  [rti_pkg::NW];
  rti_pkg::rti_side_t                         side_d [rti_pkg::NW];
  logic [rti_pkg::SW-1:0]                     den_d  [rti_pkg::NW];
  logic [rti_pkg::NLANE-1:0][rti_pkg::SW-1:0] rem_d  [rti_pkg::NW];
  logic [rti_pkg::NLANE-1:0][rti_pkg::NW-1:0] nq_d   [rti_pkg::NW];

  // Each stage shifts in one dividend bit and tries one subtract per lane
  always_comb begin
    logic [rti_pkg::SW:0]   trial;
    logic [rti_pkg::SW:0]   diff;
    logic [rti_pkg::SW-1:0] rs;
    logic [rti_pkg::NW-1:0] ns;
    for (int k = 0; k < rti_pkg::NW; k++) begin
      if (k == 0) begin
        vld_d[k]  = valid_i;
        side_d[k] = side_i;
        den_d[k]  = den_i;
      end else begin
        vld_d[k]  = vld_q[k-1];
        side_d[k] = side_q[k-1];
        den_d[k]  = den_q[k-1];
      end
      for (int l = 0; l < rti_pkg::NLANE; l++) begin
        if (k == 0) begin
          rs = '0;
          ns = num_i[l];
        end else begin
          rs = rem_q[k-1][l];
          ns = nq_q[k-1][l];
        end
        trial = {rs, ns[rti_pkg::NW-1]};
        diff  = trial - {1'b0, den_d[k]};
        if (!diff[rti_pkg::SW]) begin
          rem_d[k][l] = diff[rti_pkg::SW-1:0];
          nq_d[k][l]  = {ns[rti_pkg::NW-2:0], 1'b1};
        end else begin
          rem_d[k][l] = trial[rti_pkg::SW-1:0];
          nq_d[k][l]  = {ns[rti_pkg::NW-2:0], 1'b0};
        end
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < rti_pkg::NW; k++) vld_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < rti_pkg::NW; k++) vld_q[k] <= vld_d[k];
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < rti_pkg::NW; k++) begin
      side_q[k] <= side_d[k];
      den_q[k]  <= den_d[k];
      rem_q[k]  <= rem_d[k];
      nq_q[k]   <= nq_d[k];
    end
  end

  assign valid_o = vld_q[rti_pkg::NW-1];
  assign side_o  = side_q[rti_pkg::NW-1];
  assign quo_o   = nq_q[rti_pkg::NW-1];

endmodule

// File: hdl/ray_triangle_intersection_top.sv
// Top level of the pipelined Moller-Trumbore ray-triangle intersection block
//
//  channel   handshake                  payload
//  -------   -------------------------  -----------------------------------
//  config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//  triangle  start_i / busy_o           vert_a_x_i .. vert_c_z_i
//  result    out_valid_o (strobe)       hit_o, hit_distance_o
//
// One triangle enters every cycle; it passes 78 register stages before its result
// strobe reaches the ports: six stages of edges, cross and dot products, 70
// divider stages (one quotient bit each, shared divisor for u, v and t), then
// sign and bound stages. busy_o stays low, cfg_ready_o stays high. Reset clears
// all valid bits and loads the register reset values. Nothing stalls.
`include "ray_triangle_intersection_top_assert.svh"

module ray_triangle_intersection_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rti_pkg::CFG_AW-1:0]   cfg_index_i,
  input  logic [rti_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [rti_pkg::CW-1:0] vert_a_x_i,
  input  logic signed [rti_pkg::CW-1:0] vert_a_y_i,
  input  logic signed [rti_pkg::CW-1:0] vert_a_z_i,
  input  logic signed [rti_pkg::CW-1:0] vert_b_x_i,
  input  logic signed [rti_pkg::CW-1:0] vert_b_y_i,
  input  logic signed [rti_pkg::CW-1:0] vert_b_z_i,
  input  logic signed [rti_pkg::CW-1:0] vert_c_x_i,
  input  logic signed [rti_pkg::CW-1:0] vert_c_y_i,
  input  logic signed [rti_pkg::CW-1:0] vert_c_z_i,
  output logic                         out_valid_o,
  output logic                         hit_o,
  output logic signed [rti_pkg::OW-1:0] hit_distance_o
);

  // Configuration registers
  logic signed [rti_pkg::CW-1:0] org_q [3];
  logic signed [rti_pkg::CW-1:0] dir_q [3];
  logic [rti_pkg::FLOORW-1:0]    floor_q;
  logic [rti_pkg::MARGW-1:0]     margin_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= '0;
        dir_q[i] <= '0;
      end
      floor_q  <= rti_pkg::FLOORW'(1);
      margin_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rti_pkg::REG_ORG_X:  org_q[0] <= cfg_data_i[rti_pkg::CW-1:0];
        rti_pkg::REG_ORG_Y:  org_q[1] <= cfg_data_i[rti_pkg::CW-1:0];
        rti_pkg::REG_ORG_Z:  org_q[2] <= cfg_data_i[rti_pkg::CW-1:0];
        rti_pkg::REG_DIR_X:  dir_q[0] <= cfg_data_i[rti_pkg::CW-1:0];
        rti_pkg::REG_DIR_Y:  dir_q[1] <= cfg_data_i[rti_pkg::CW-1:0];
        rti_pkg::REG_DIR_Z:  dir_q[2] <= cfg_data_i[rti_pkg::CW-1:0];
        rti_pkg::REG_FLOOR:  floor_q  <= cfg_data_i[rti_pkg::FLOORW-1:0];
        rti_pkg::REG_MARGIN: margin_q <= cfg_data_i[rti_pkg::MARGW-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits of the front stages and the tail
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q;
  logic q1_vld_q;
  logic div_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      s5_vld_q    <= 1'b0;
      s6_vld_q    <= 1'b0;
      q1_vld_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      s1_vld_q    <= start_i && !busy_o;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      s4_vld_q    <= s3_vld_q;
      s5_vld_q    <= s4_vld_q;
      s6_vld_q    <= s5_vld_q;
      q1_vld_q    <= div_vld;
      out_valid_o <= q1_vld_q;
    end
  end

  // Stage 1: edges and origin offset
  logic signed [rti_pkg::EW-1:0] e1_1q [3], e2_1q [3], s_1q [3];

  always_ff @(posedge clk_i) begin
    e1_1q[0] <= rti_pkg::EW'(vert_b_x_i) - rti_pkg::EW'(vert_a_x_i);
    e1_1q[1] <= rti_pkg::EW'(vert_b_y_i) - rti_pkg::EW'(vert_a_y_i);
    e1_1q[2] <= rti_pkg::EW'(vert_b_z_i) - rti_pkg::EW'(vert_a_z_i);
    e2_1q[0] <= rti_pkg::EW'(vert_c_x_i) - rti_pkg::EW'(vert_a_x_i);
    e2_1q[1] <= rti_pkg::EW'(vert_c_y_i) - rti_pkg::EW'(vert_a_y_i);
    e2_1q[2] <= rti_pkg::EW'(vert_c_z_i) - rti_pkg::EW'(vert_a_z_i);
    s_1q[0]  <= rti_pkg::EW'(org_q[0]) - rti_pkg::EW'(vert_a_x_i);
    s_1q[1]  <= rti_pkg::EW'(org_q[1]) - rti_pkg::EW'(vert_a_y_i);
    s_1q[2]  <= rti_pkg::EW'(org_q[2]) - rti_pkg::EW'(vert_a_z_i);
  end

  // Stage 2: cross product terms of dir x e2 and s x e1
  logic signed [rti_pkg::PW-1:0] pp_q [6];
  logic signed [rti_pkg::QW-1:0] qp_q [6];
  logic signed [rti_pkg::EW-1:0] e1_2q [3], e2_2q [3], s_2q [3];

  always_ff @(posedge clk_i) begin
    pp_q[0] <= rti_pkg::PW'(dir_q[1]) * rti_pkg::PW'(e2_1q[2]);
    pp_q[1] <= rti_pkg::PW'(dir_q[2]) * rti_pkg::PW'(e2_1q[1]);
    pp_q[2] <= rti_pkg::PW'(dir_q[2]) * rti_pkg::PW'(e2_1q[0]);
    pp_q[3] <= rti_pkg::PW'(dir_q[0]) * rti_pkg::PW'(e2_1q[2]);
    pp_q[4] <= rti_pkg::PW'(dir_q[0]) * rti_pkg::PW'(e2_1q[1]);
    pp_q[5] <= rti_pkg::PW'(dir_q[1]) * rti_pkg::PW'(e2_1q[0]);
    qp_q[0] <= rti_pkg::QW'(s_1q[1]) * rti_pkg::QW'(e1_1q[2]);
    qp_q[1] <= rti_pkg::QW'(s_1q[2]) * rti_pkg::QW'(e1_1q[1]);
    qp_q[2] <= rti_pkg::QW'(s_1q[2]) * rti_pkg::QW'(e1_1q[0]);
    qp_q[3] <= rti_pkg::QW'(s_1q[0]) * rti_pkg::QW'(e1_1q[2]);
    qp_q[4] <= rti_pkg::QW'(s_1q[0]) * rti_pkg::QW'(e1_1q[1]);
    qp_q[5] <= rti_pkg::QW'(s_1q[1]) * rti_pkg::QW'(e1_1q[0]);
    e1_2q   <= e1_1q;
    e2_2q   <= e2_1q;
    s_2q    <= s_1q;
  end

  // Stage 3: finish p and q
  logic signed [rti_pkg::PW-1:0] p_q [3];
  logic signed [rti_pkg::QW-1:0] q_q [3];
  logic signed [rti_pkg::EW-1:0] e1_3q [3], e2_3q [3], s_3q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      p_q[i] <= pp_q[2*i] - pp_q[2*i+1];
      q_q[i] <= qp_q[2*i] - qp_q[2*i+1];
    end
    e1_3q <= e1_2q;
    e2_3q <= e2_2q;
    s_3q  <= s_2q;
  end

  // Stage 4: dot product terms
  logic signed [rti_pkg::SW-1:0] det_t_q [3], u_t_q [3], v_t_q [3], t_t_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      det_t_q[i] <= rti_pkg::SW'(e1_3q[i]) * rti_pkg::SW'(p_q[i]);
      u_t_q[i]   <= rti_pkg::SW'(s_3q[i]) * rti_pkg::SW'(p_q[i]);
      v_t_q[i]   <= rti_pkg::SW'(dir_q[i]) * rti_pkg::SW'(q_q[i]);
      t_t_q[i]   <= rti_pkg::SW'(e2_3q[i]) * rti_pkg::SW'(q_q[i]);
    end
  end

  // Stage 5: sum the terms
  logic signed [rti_pkg::SW-1:0] det_q, nu_q, nv_q, nt_q;

  always_ff @(posedge clk_i) begin
    det_q <= det_t_q[0] + det_t_q[1] + det_t_q[2];
    nu_q  <= u_t_q[0] + u_t_q[1] + u_t_q[2];
    nv_q  <= v_t_q[0] + v_t_q[1] + v_t_q[2];
    nt_q  <= t_t_q[0] + t_t_q[1] + t_t_q[2];
  end

  // Stage 6: magnitudes, quotient signs and the parallel-ray test
  logic [rti_pkg::SW-1:0]                     den_d, den_q;
  logic [rti_pkg::NLANE-1:0][rti_pkg::NW-1:0] num_d, num_q;
  rti_pkg::rti_side_t                         side_d, side_q;

  always_comb begin
    logic signed [rti_pkg::SW-1:0] n [rti_pkg::NLANE];
    logic [rti_pkg::SW-1:0]        mag;
    n[rti_pkg::LANE_U] = nu_q;
    n[rti_pkg::LANE_V] = nv_q;
    n[rti_pkg::LANE_T] = nt_q;
    den_d = det_q[rti_pkg::SW-1] ? rti_pkg::SW'(-det_q) : rti_pkg::SW'(det_q);
    for (int l = 0; l < rti_pkg::NLANE; l++) begin
      mag = n[l][rti_pkg::SW-1] ? rti_pkg::SW'(-n[l]) : rti_pkg::SW'(n[l]);
      num_d[l] = {mag, {rti_pkg::FRAC{1'b0}}};
      side_d.q_neg[l] = n[l][rti_pkg::SW-1] ^ det_q[rti_pkg::SW-1];
    end
    side_d.det_miss = (det_q == '0) ||
                      (den_d < {{(rti_pkg::SW-rti_pkg::FLOORW){1'b0}}, floor_q});
  end

  // Hold a non-zero divisor so the divider result stays defined
  always_ff @(posedge clk_i) begin
    den_q  <= (den_d == '0) ? rti_pkg::SW'(1) : den_d;
    num_q  <= num_d;
    side_q <= side_d;
  end

  // Divider
  rti_pkg::rti_side_t                         div_side;
  logic [rti_pkg::NLANE-1:0][rti_pkg::NW-1:0] div_quo;

  rti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s6_vld_q),
    .side_i  (side_q),
    .den_i   (den_q),
    .num_i   (num_q),
    .valid_o (div_vld),
    .side_o  (div_side),
    .quo_o   (div_quo)
  );

  // Tail 1: apply the quotient signs
  logic signed [rti_pkg::NW:0] u_q, v_q, t_q;
  logic                        q1_miss_q;

  always_ff @(posedge clk_i) begin
    u_q <= div_side.q_neg[rti_pkg::LANE_U] ? -$signed({1'b0, div_quo[rti_pkg::LANE_U]})
                                           :  $signed({1'b0, div_quo[rti_pkg::LANE_U]});
    v_q <= div_side.q_neg[rti_pkg::LANE_V] ? -$signed({1'b0, div_quo[rti_pkg::LANE_V]})
                                           :  $signed({1'b0, div_quo[rti_pkg::LANE_V]});
    t_q <= div_side.q_neg[rti_pkg::LANE_T] ? -$signed({1'b0, div_quo[rti_pkg::LANE_T]})
                                           :  $signed({1'b0, div_quo[rti_pkg::LANE_T]});
    q1_miss_q <= div_side.det_miss;
  end

  // Tail 2: barycentric bounds and distance saturation
  logic                 hit_d;
  logic [rti_pkg::OW-1:0] dist_d;

  always_comb begin
    logic signed [rti_pkg::NW+1:0] ux, vx, mx, hi;
    logic                          u_bad, v_bad, fits;
    ux    = {u_q[rti_pkg::NW], u_q};
    vx    = {v_q[rti_pkg::NW], v_q};
    mx    = {{(rti_pkg::NW+2-rti_pkg::MARGW){1'b0}}, margin_q};
    hi    = rti_pkg::ONE_W + mx;
    u_bad = (ux < -mx) || (ux > hi);
    v_bad = (vx < -mx) || ((ux + vx) > hi);
    hit_d = !q1_miss_q && !u_bad && !v_bad;
    fits  = (t_q[rti_pkg::NW:rti_pkg::OW-1] == '0) ||
            (t_q[rti_pkg::NW:rti_pkg::OW-1] == '1);
    if (!hit_d) begin
      dist_d = rti_pkg::DIST_MAX;
    end else if (fits) begin
      dist_d = t_q[rti_pkg::OW-1:0];
    end else if (t_q[rti_pkg::NW]) begin
      dist_d = rti_pkg::DIST_MIN;
    end else begin
      dist_d = rti_pkg::DIST_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o          <= hit_d;
    hit_distance_o <= dist_d;
  end

  // Checks
  `RTI_ASSERT_IMP(a_miss_max, clk_i, rst_ni, out_valid_o && !hit_o,
                  hit_distance_o == rti_pkg::DIST_MAX, "miss without maximum distance")
  `RTI_ASSERT_NXT(a_det_miss, clk_i, rst_ni, q1_vld_q && q1_miss_q,
                  out_valid_o && !hit_o, "parallel ray reported as hit")
  `RTI_ASSERT_LAT(a_latency, clk_i, rst_ni, start_i && !busy_o, rti_pkg::LAT_OUT,
                  out_valid_o, "item result missing at fixed latency")

endmodule

// File: sim/tb_ray_triangle_intersection_top.sv
// Self-checking testbench for the pipelined ray-triangle intersection block
`timescale 1ns / 100ps

module tb_ray_triangle_intersection_top;

  typedef logic [8:0][rti_pkg::CW-1:0] tri_t;
  typedef struct packed {
    logic                   hit;
    logic [rti_pkg::OW-1:0] hit_dist;
  } isect_t;

  localparam int LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [rti_pkg::CFG_AW-1:0] cfg_index_i = '0;
  logic [rti_pkg::CFG_DW-1:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  tri_t verts = '0;
  logic out_valid_o, hit_o;
  logic signed [rti_pkg::OW-1:0] hit_distance_o;

  ray_triangle_intersection_top u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .start_i, .busy_o,
    .vert_a_x_i(verts[0]), .vert_a_y_i(verts[1]), .vert_a_z_i(verts[2]),
    .vert_b_x_i(verts[3]), .vert_b_y_i(verts[4]), .vert_b_z_i(verts[5]),
    .vert_c_x_i(verts[6]), .vert_c_y_i(verts[7]), .vert_c_z_i(verts[8]),
    .out_valid_o, .hit_o, .hit_distance_o
  );

  // Clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the ray and the thresholds
  logic signed [rti_pkg::CW-1:0] ray_org [3];
  logic signed [rti_pkg::CW-1:0] ray_dir [3];
  logic [rti_pkg::FLOORW-1:0] det_floor;
  logic [rti_pkg::MARGW-1:0] bary_margin;

  tri_t   pending_tris [$];
  isect_t expected_hits [$];
  int     n_fail = 0;
  int     n_driven = 0;
  int     n_taken = 0;
  int     gap_left = 0;
  bit     no_gaps = 0;
  int     cycles = 0;

  task automatic report(input string what, input logic [rti_pkg::OW-1:0] got,
                        input logic [rti_pkg::OW-1:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
    n_fail++;
  endtask

  function automatic longint dot3(input longint x[3], input longint y[3]);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  function automatic void cross3(input longint x[3], input longint y[3], output longint r[3]);
    r[0] = x[1] * y[2] - x[2] * y[1];
    r[1] = x[2] * y[0] - x[0] * y[2];
    r[2] = x[0] * y[1] - x[1] * y[0];
  endfunction

  // Moller-Trumbore in exact wide arithmetic
  function automatic isect_t predict_hit(input tri_t tr);
    longint a[3], e1[3], e2[3], s[3], p[3], q[3], dr[3];
    logic signed [127:0] det, adet, u, v, t, lo, hi;
    isect_t r;
    for (int i = 0; i < 3; i++) begin
      a[i]  = $signed(tr[i]);
      e1[i] = longint'($signed(tr[3+i])) - a[i];
      e2[i] = longint'($signed(tr[6+i])) - a[i];
      s[i]  = longint'(ray_org[i]) - a[i];
      dr[i] = ray_dir[i];
    end
    r.hit = 1'b0;
    r.hit_dist = rti_pkg::DIST_MAX;
    cross3(dr, e2, p);
    det = dot3(e1, p);
    if (det == 0) return r;
    adet = (det < 0) ? -det : det;
    if (adet < $signed({96'b0, det_floor})) return r;
    cross3(s, e1, q);
    lo = -$signed({112'b0, bary_margin});
    hi = 128'sd65536 + $signed({112'b0, bary_margin});
    u = $signed(128'(dot3(s, p))) * 128'sd65536 / det;
    if (u < lo || u > hi) return r;
    v = $signed(128'(dot3(dr, q))) * 128'sd65536 / det;
    if (v < lo || u + v > hi) return r;
    t = $signed(128'(dot3(e2, q))) * 128'sd65536 / det;
    r.hit = 1'b1;
    if (t > 128'sh7FFF_FFFF_FFFF) r.hit_dist = rti_pkg::DIST_MAX;
    else if (t < -128'sh8000_0000_0000) r.hit_dist = rti_pkg::DIST_MIN;
    else r.hit_dist = t[rti_pkg::OW-1:0];
    return r;
  endfunction

  // Accept an item and queue its expected result
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      expected_hits.push_back(predict_hit(verts));
      n_taken <= n_taken + 1;
    end
  end

  // Check each result strobe against the oldest expectation
  always @(posedge clk_i) begin
    isect_t want;
    if (rst_ni && out_valid_o) begin
      if (expected_hits.size() == 0) begin
        report("unexpected result", rti_pkg::OW'(hit_o), '0);
      end else begin
        want = expected_hits.pop_front();
        if (hit_o !== want.hit) report("hit", rti_pkg::OW'(hit_o), rti_pkg::OW'(want.hit));
        if (hit_distance_o !== want.hit_dist) report("distance", hit_distance_o, want.hit_dist);
      end
    end
  end

  // Drive items with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && n_taken == n_driven) begin
      if (gap_left > 0) begin
        start_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_tris.size() != 0) begin
        verts <= pending_tris.pop_front();
        start_i <= 1'b1;
        n_driven <= n_driven + 1;
        if (no_gaps || $urandom_range(0, 9) < 6) gap_left <= 0;
        else if ($urandom_range(0, 9) < 9) gap_left <= $urandom_range(1, 3);
        else gap_left <= $urandom_range(10, 40);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [rti_pkg::CFG_AW-1:0] idx,
                           input logic [rti_pkg::CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      rti_pkg::REG_ORG_X:  ray_org[0] = val[rti_pkg::CW-1:0];
      rti_pkg::REG_ORG_Y:  ray_org[1] = val[rti_pkg::CW-1:0];
      rti_pkg::REG_ORG_Z:  ray_org[2] = val[rti_pkg::CW-1:0];
      rti_pkg::REG_DIR_X:  ray_dir[0] = val[rti_pkg::CW-1:0];
      rti_pkg::REG_DIR_Y:  ray_dir[1] = val[rti_pkg::CW-1:0];
      rti_pkg::REG_DIR_Z:  ray_dir[2] = val[rti_pkg::CW-1:0];
      rti_pkg::REG_FLOOR:  det_floor = val;
      rti_pkg::REG_MARGIN: bary_margin = val[rti_pkg::MARGW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_ray(input int ox, oy, oz, dx, dy, dz,
                         input logic [31:0] fl, input logic [15:0] mg);
    write_reg(rti_pkg::REG_ORG_X, 32'(ox));
    write_reg(rti_pkg::REG_ORG_Y, 32'(oy));
    write_reg(rti_pkg::REG_ORG_Z, 32'(oz));
    write_reg(rti_pkg::REG_DIR_X, 32'(dx));
    write_reg(rti_pkg::REG_DIR_Y, 32'(dy));
    write_reg(rti_pkg::REG_DIR_Z, 32'(dz));
    write_reg(rti_pkg::REG_FLOOR, fl);
    write_reg(rti_pkg::REG_MARGIN, {16'b0, mg});
  endtask

  // Hold until every item is taken and every result seen
  task automatic drain();
    while (pending_tris.size() != 0 || n_taken != n_driven || expected_hits.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic logic [rti_pkg::CW-1:0] clamp16(input longint x);
    if (x > 32767) return 16'h7FFF;
    if (x < -32768) return 16'h8000;
    return x[rti_pkg::CW-1:0];
  endfunction

  function automatic tri_t tri_of(input int ax, ay, az, bx, by, bz, cx, cy, cz);
    return {cz[15:0], cy[15:0], cx[15:0], bz[15:0], by[15:0], bx[15:0],
            az[15:0], ay[15:0], ax[15:0]};
  endfunction

  // Triangle around a point on the current ray, mostly in front of the origin
  function automatic tri_t aimed_tri();
    tri_t tr;
    longint k, pt, spread;
    k = $urandom_range(0, 9) < 8 ? longint'($urandom_range(0, 20)) : -longint'($urandom_range(1, 5));
    spread = $urandom_range(1, 3000);
    for (int i = 0; i < 3; i++) begin
      pt = longint'(ray_org[i]) + k * longint'(ray_dir[i]);
      for (int j = 0; j < 3; j++)
        tr[3*j+i] = clamp16(pt + longint'($urandom_range(0, 2 * spread)) - spread);
    end
    return tr;
  endfunction

  function automatic tri_t noise_tri();
    tri_t tr;
    for (int i = 0; i < 9; i++) tr[i] = 16'($urandom_range(0, 65535));
    return tr;
  endfunction

  initial begin
    int dmax, omax;
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, 0};
    det_floor = 1;
    bary_margin = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset ray has no direction: every triangle misses
    repeat (4) pending_tris.push_back(noise_tri());
    drain();

    // Directed: ray along +z from below the xy plane, no floor, no margin
    set_ray(0, 0, -100, 0, 0, 1, 32'd0, 16'd0);
    pending_tris.push_back(tri_of(-10, -10, 0, 30, -10, 0, -10, 30, 0));
    pending_tris.push_back(tri_of(0, 0, 0, 10, 0, 0, 0, 10, 0));
    pending_tris.push_back(tri_of(-10, 0, 0, 10, 0, 0, 0, 10, 0));
    pending_tris.push_back(tri_of(-10, -10, -200, 30, -10, -200, -10, 30, -200));
    pending_tris.push_back(tri_of(5, 5, 5, 5, 5, 5, 5, 5, 5));
    pending_tris.push_back(tri_of(0, 0, 0, 0, 10, 0, 0, 0, 10));
    pending_tris.push_back(tri_of(100, 100, 0, 200, 100, 0, 100, 200, 0));
    pending_tris.push_back(tri_of(-10, 30, 0, 30, -10, 0, -10, -10, 0));
    pending_tris.push_back({9{16'h8000}});
    pending_tris.push_back({9{16'h7FFF}});
    pending_tris.push_back(tri_of(-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0));
    pending_tris.push_back(tri_of(-32768, -32768, 32767, 32767, -32768, 32767,
                                  -32768, 32767, 32767));
    pending_tris.push_back(tri_of(32767, 32767, -32768, -32768, 32767, -32768,
                                  32767, -32768, -32768));
    repeat (6) pending_tris.push_back(noise_tri());
    drain();

    // Random phases over floor and margin extremes and ray ranges
    for (int ph = 0; ph < 8; ph++) begin
      dmax = (ph == 5) ? 32767 : 300;
      omax = (ph == 5) ? 32767 : 8000;
      no_gaps = (ph == 3);
      set_ray($urandom_range(0, 2 * omax) - omax, $urandom_range(0, 2 * omax) - omax,
              $urandom_range(0, 2 * omax) - omax, $urandom_range(0, 2 * dmax) - dmax,
              $urandom_range(0, 2 * dmax) - dmax, $urandom_range(0, 2 * dmax) - dmax,
              ph == 1 ? 32'hFFFF_FFFF : ph == 2 ? 32'd0 : $urandom_range(0, 4000),
              ph == 2 ? 16'hFFFF : ph == 4 ? 16'd0 : 16'($urandom_range(0, 3000)));
      if (ph == 6) set_ray(-32768, 32767, -32768, -32768, 32767, -32768, 32'd1, 16'h8000);
      for (int n = 0; n < 78; n++)
        pending_tris.push_back($urandom_range(0, 9) < 8 ? aimed_tri() : noise_tri());
      drain();
    end

    repeat (rti_pkg::LAT_OUT + 20) @(posedge clk_i);
    if (n_fail == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
